FILE: hdl/bcf_pkg.sv
// Shared types, constants and the interpolation function of the Bezier flattener.
`timescale 1ns / 1ps
`default_nettype none
package bcf_pkg;

  localparam int unsigned COORD_W      = 24;
  localparam int unsigned T_W          = 17;
  localparam int unsigned STEP_W       = 16;
  localparam int unsigned NSEG_W       = 7;
  localparam int unsigned SAMPLE_IDX_W = 6;
  localparam int unsigned CFG_IDX_W    = 4;
  localparam int unsigned CFG_DATA_W   = 16;

  localparam int unsigned MAX_SEGMENTS     = 64;
  localparam int unsigned DEFAULT_SEGMENTS = 10;
  localparam int unsigned DEFAULT_T_STEP   = 6554;

  localparam logic [T_W-1:0] T_ONE = 17'h10000;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t COORD_MAX = 24'sh7FFFFF;
  localparam coord_t COORD_MIN = 24'sh800000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_SEGMENTS = 4'd0,
    REG_T_STEP       = 4'd1
  } cfg_reg_e;

  typedef struct packed {
    coord_t p0_x;
    coord_t p0_y;
    coord_t p1_x;
    coord_t p1_y;
    coord_t p2_x;
    coord_t p2_y;
    coord_t p3_x;
    coord_t p3_y;
  } seg_t;

  typedef struct packed {
    coord_t                  pt_x;
    coord_t                  pt_y;
    logic [SAMPLE_IDX_W-1:0] sample_index;
    logic                    last;
  } pt_t;

  // Sample tag that travels down the cell row next to the points.
  typedef struct packed {
    logic                    valid;
    logic [T_W-1:0]          t;
    logic [SAMPLE_IDX_W-1:0] idx;
    logic                    last;
  } tag_t;

  // a + (b - a) * t, rounded to nearest with ties up; result stays between a and b.
  function automatic coord_t lerp(coord_t a, coord_t b, logic [T_W-1:0] t);
    logic signed [COORD_W:0]         diff;
    logic signed [T_W:0]             ts;
    logic signed [COORD_W+T_W+1:0]   prod;
    logic signed [COORD_W+T_W+1:0]   acc;
    diff = (COORD_W+1)'(a);
    diff = (COORD_W+1)'(b) - diff;
    ts   = signed'({1'b0, t});
    prod = diff * ts;
    acc  = prod + {{(T_W+2-16){a[COORD_W-1]}}, a, 16'h0000}
                + (COORD_W+T_W+2)'(32768);
    return acc[COORD_W+15:16];
  endfunction

endpackage
`default_nettype wire

FILE: hdl/bcf_seg_if.sv
// Input channel: one word holds the four control points of a segment.
`timescale 1ns / 1ps
`default_nettype none
interface bcf_seg_if;
  logic          valid;
  logic          ready;
  bcf_pkg::seg_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/bcf_pt_if.sv
// Output channel: one word holds one sampled curve point.
`timescale 1ns / 1ps
`default_nettype none
interface bcf_pt_if;
  logic         valid;
  logic         ready;
  bcf_pkg::pt_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/bcf_cfg_if.sv
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps
`default_nettype none
interface bcf_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [bcf_pkg::CFG_IDX_W-1:0]      index;
  logic [bcf_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/cubic_bezier_flattener_unit.sv
// Top level of the cubic Bezier flattener: registers, sequencer and the row of cells.
// The first point of a segment is registered in the sequencer, then in each cell in turn,
// before it is offered. One point per cycle while the output takes them; a segment holds
// the input off until its last sample is issued, and only then is the next one taken.
// The row of three interpolation cells advances as one and stalls when the output waits.
// Reset clears the run and the valid bits and loads 10 segments and a step of 6554.
`timescale 1ns / 1ps
`default_nettype none
module cubic_bezier_flattener_unit #(
  parameter int unsigned MAX_SEGMENTS = bcf_pkg::MAX_SEGMENTS
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bcf_seg_if.sink   seg_i,
  bcf_pt_if.source  pt_o,
  bcf_cfg_if.sink   cfg_i
);

  logic [bcf_pkg::NSEG_W-1:0] num_segments_q;
  logic [bcf_pkg::STEP_W-1:0] t_step_q;
  bcf_pkg::coord_t            px_q [4];
  bcf_pkg::coord_t            py_q [4];

  logic            busy;
  logic            start;
  logic            adv;
  bcf_pkg::tag_t   tag0, tag1, tag2, tag3;
  bcf_pkg::coord_t x1 [3];
  bcf_pkg::coord_t y1 [3];
  bcf_pkg::coord_t x2 [2];
  bcf_pkg::coord_t y2 [2];
  bcf_pkg::coord_t x3 [1];
  bcf_pkg::coord_t y3 [1];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_segments_q <= bcf_pkg::NSEG_W'(bcf_pkg::DEFAULT_SEGMENTS);
      t_step_q       <= bcf_pkg::STEP_W'(bcf_pkg::DEFAULT_T_STEP);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        bcf_pkg::REG_NUM_SEGMENTS: num_segments_q <= cfg_i.data[bcf_pkg::NSEG_W-1:0];
        bcf_pkg::REG_T_STEP:       t_step_q       <= cfg_i.data[bcf_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign seg_i.ready = !busy;
  assign start       = seg_i.valid && !busy;

  always_ff @(posedge clk_i) begin
    if (start) begin
      px_q[0] <= seg_i.data.p0_x;
      px_q[1] <= seg_i.data.p1_x;
      px_q[2] <= seg_i.data.p2_x;
      px_q[3] <= seg_i.data.p3_x;
      py_q[0] <= seg_i.data.p0_y;
      py_q[1] <= seg_i.data.p1_y;
      py_q[2] <= seg_i.data.p2_y;
      py_q[3] <= seg_i.data.p3_y;
    end
  end

  // advance the whole row unless a finished point is still waiting
  assign adv = !tag3.valid || pt_o.ready;

  bcf_seq #(
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .en_i           (adv),
    .num_segments_i (num_segments_q),
    .t_step_i       (t_step_q),
    .busy_o         (busy),
    .tag_o          (tag0)
  );

  bcf_cell #(.NPTS(4)) u_cell_l1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .tag_i  (tag0),
    .x_i    (px_q),
    .y_i    (py_q),
    .tag_o  (tag1),
    .x_o    (x1),
    .y_o    (y1)
  );

  bcf_cell #(.NPTS(3)) u_cell_l2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .tag_i  (tag1),
    .x_i    (x1),
    .y_i    (y1),
    .tag_o  (tag2),
    .x_o    (x2),
    .y_o    (y2)
  );

  bcf_cell #(.NPTS(2)) u_cell_l3 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .tag_i  (tag2),
    .x_i    (x2),
    .y_i    (y2),
    .tag_o  (tag3),
    .x_o    (x3),
    .y_o    (y3)
  );

  assign pt_o.valid             = tag3.valid;
  assign pt_o.data.pt_x         = x3[0];
  // negate y; the most negative code saturates to the largest positive one
  assign pt_o.data.pt_y         = (y3[0] == bcf_pkg::COORD_MIN) ? bcf_pkg::COORD_MAX : -y3[0];
  assign pt_o.data.sample_index = tag3.idx;
  assign pt_o.data.last         = tag3.last;

endmodule
`default_nettype wire

FILE: hdl/bcf_cell.sv
// One de Casteljau level: interpolates neighboring points of x and y, then registers.
`timescale 1ns / 1ps
`default_nettype none
module bcf_cell #(
  parameter int unsigned NPTS = 4
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire bcf_pkg::tag_t   tag_i,
  input  wire bcf_pkg::coord_t x_i [NPTS],
  input  wire bcf_pkg::coord_t y_i [NPTS],
  output bcf_pkg::tag_t        tag_o,
  output bcf_pkg::coord_t      x_o [NPTS-1],
  output bcf_pkg::coord_t      y_o [NPTS-1]
);

  localparam int unsigned NOUT = NPTS - 1;

  bcf_pkg::tag_t   tag_q;
  bcf_pkg::coord_t x_d [NOUT];
  bcf_pkg::coord_t y_d [NOUT];
  bcf_pkg::coord_t x_q [NOUT];
  bcf_pkg::coord_t y_q [NOUT];

  always_comb begin
    for (int k = 0; k < NOUT; k++) begin
      x_d[k] = bcf_pkg::lerp(x_i[k], x_i[k+1], tag_i.t);
      y_d[k] = bcf_pkg::lerp(y_i[k], y_i[k+1], tag_i.t);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else if (en_i) begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  assign tag_o = tag_q;
  assign x_o   = x_q;
  assign y_o   = y_q;

endmodule
`default_nettype wire

FILE: hdl/bcf_seq.sv
// Sample sequencer: steps the sample index and t once per advancing cycle.
`timescale 1ns / 1ps
`default_nettype none
module bcf_seq #(
  parameter int unsigned MAX_SEGMENTS = bcf_pkg::MAX_SEGMENTS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic                          en_i,
  input  wire logic [bcf_pkg::NSEG_W-1:0]    num_segments_i,
  input  wire logic [bcf_pkg::STEP_W-1:0]    t_step_i,
  output logic                               busy_o,
  output bcf_pkg::tag_t                      tag_o
);

  localparam int unsigned IDX_W = $clog2(MAX_SEGMENTS);

  logic                    busy_q, busy_d;
  logic [IDX_W-1:0]        idx_q, idx_d;
  logic [IDX_W-1:0]        last_q, last_d;
  logic [bcf_pkg::T_W-1:0] t_q, t_d;
  logic [bcf_pkg::T_W:0]   t_sum;
  logic [IDX_W-1:0]        last_idx;

  // Zero segments counts as one, anything past the maximum as the maximum.
  always_comb begin
    if (num_segments_i == '0) begin
      last_idx = '0;
    end else if (num_segments_i > bcf_pkg::NSEG_W'(MAX_SEGMENTS)) begin
      last_idx = IDX_W'(MAX_SEGMENTS - 1);
    end else begin
      last_idx = IDX_W'(num_segments_i - bcf_pkg::NSEG_W'(1));
    end
  end

  assign t_sum = (bcf_pkg::T_W+1)'(t_q) + (bcf_pkg::T_W+1)'(t_step_i);

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    last_d = last_q;
    t_d    = t_q;
    if (start_i) begin
      busy_d = 1'b1;
      idx_d  = '0;
      last_d = last_idx;
      t_d    = '0;
    end else if (busy_q && en_i) begin
      if (idx_q == last_q) begin
        busy_d = 1'b0;
        idx_d  = '0;
      end else begin
        idx_d = idx_q + IDX_W'(1);
        // hold t at one once the step runs past the end
        if (t_sum > (bcf_pkg::T_W+1)'(bcf_pkg::T_ONE)) begin
          t_d = bcf_pkg::T_ONE;
        end else begin
          t_d = t_sum[bcf_pkg::T_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      last_q <= '0;
      t_q    <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      last_q <= last_d;
      t_q    <= t_d;
    end
  end

  assign busy_o      = busy_q;
  assign tag_o.valid = busy_q;
  assign tag_o.t     = t_q;
  assign tag_o.idx   = bcf_pkg::SAMPLE_IDX_W'(idx_q);
  assign tag_o.last  = (idx_q == last_q);

endmodule
`default_nettype wire

FILE: bench/cubic_bezier_flattener_unit_tb.sv
// Self-checking bench for the cubic Bezier flattener: random segments against a sample predictor.
`timescale 1ns / 1ps
module cubic_bezier_flattener_unit_tb;

  localparam int unsigned MAX_GAP       = 8;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned RAND_PHASES   = 8;
  localparam int unsigned PHASE_WORDS   = 32;
  localparam longint      T_UNIT        = 65536;
  localparam longint      ROUND_HALF    = 32768;
  localparam int unsigned NSEG_FIELD_MAX = (1 << bcf_pkg::NSEG_W) - 1;
  localparam logic [bcf_pkg::CFG_IDX_W-1:0] FIRST_UNUSED_REG = bcf_pkg::CFG_IDX_W'(2);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bcf_seg_if seg_if ();
  bcf_pt_if  pt_if ();
  bcf_cfg_if cfg_if ();

  cubic_bezier_flattener_unit i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .seg_i (seg_if),
    .pt_o  (pt_if),
    .cfg_i (cfg_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Bench copy of the registers, updated on each accepted configuration word.
  logic [bcf_pkg::NSEG_W-1:0] cfg_segments = bcf_pkg::NSEG_W'(bcf_pkg::DEFAULT_SEGMENTS);
  logic [bcf_pkg::STEP_W-1:0] cfg_step     = bcf_pkg::STEP_W'(bcf_pkg::DEFAULT_T_STEP);

  bcf_pkg::seg_t segment_queue[$];
  bcf_pkg::pt_t  pending_points[$];
  int unsigned   err_count = 0;

  // Driver and receiver state.
  bcf_pkg::seg_t seg_word;
  logic        seg_loaded = 1'b0;
  logic        seg_taken  = 1'b0;
  int unsigned seg_gap    = 0;
  logic        pt_taken   = 1'b0;
  int unsigned snk_wait   = 0;
  int unsigned snk_hold_req  = 0;
  int unsigned snk_hold_left = 0;
  logic        src_idle = 1'b0;
  logic        snk_idle = 1'b0;

  function automatic longint blend(input longint a, input longint b, input longint t);
    longint acc;
    acc = a * (T_UNIT - t) + b * t + ROUND_HALF;
    return acc >>> 16;
  endfunction

  function automatic longint bezier_at(input longint q0, input longint q1, input longint q2,
                                       input longint q3, input longint t);
    longint a, b, c, d, e;
    a = blend(q0, q1, t);
    b = blend(q1, q2, t);
    c = blend(q2, q3, t);
    d = blend(a, b, t);
    e = blend(b, c, t);
    return blend(d, e, t);
  endfunction

  // Expand one segment into its run of sampled points under the current registers.
  function automatic void flatten_segment(input bcf_pkg::seg_t seg);
    int unsigned  n;
    int unsigned  i;
    longint       t;
    longint       x;
    longint       y;
    bcf_pkg::pt_t pt;
    n = 32'(cfg_segments);
    if (n < 1) n = 1;
    if (n > bcf_pkg::MAX_SEGMENTS) n = bcf_pkg::MAX_SEGMENTS;
    for (i = 0; i < n; i++) begin
      t = longint'(i) * longint'(cfg_step);
      if (t > T_UNIT) t = T_UNIT;
      x = bezier_at($signed(seg.p0_x), $signed(seg.p1_x), $signed(seg.p2_x),
                    $signed(seg.p3_x), t);
      y = -bezier_at($signed(seg.p0_y), $signed(seg.p1_y), $signed(seg.p2_y),
                     $signed(seg.p3_y), t);
      if (x > longint'(bcf_pkg::COORD_MAX)) x = longint'(bcf_pkg::COORD_MAX);
      if (x < longint'(bcf_pkg::COORD_MIN)) x = longint'(bcf_pkg::COORD_MIN);
      if (y > longint'(bcf_pkg::COORD_MAX)) y = longint'(bcf_pkg::COORD_MAX);
      if (y < longint'(bcf_pkg::COORD_MIN)) y = longint'(bcf_pkg::COORD_MIN);
      pt.pt_x         = bcf_pkg::coord_t'(x);
      pt.pt_y         = bcf_pkg::coord_t'(y);
      pt.sample_index = bcf_pkg::SAMPLE_IDX_W'(i);
      pt.last         = (i + 1 == n);
      pending_points.insert(pending_points.size(), pt);
    end
  endfunction

  function automatic bcf_pkg::coord_t rand_coord();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return bcf_pkg::coord_t'($urandom);
    if (sel < 7) return bcf_pkg::coord_t'(int'($urandom_range(0, 4095)) - 2048);
    if (sel == 7) return bcf_pkg::COORD_MAX - bcf_pkg::coord_t'($urandom_range(0, 3));
    if (sel == 8) return bcf_pkg::COORD_MIN + bcf_pkg::coord_t'($urandom_range(0, 3));
    return bcf_pkg::coord_t'(0);
  endfunction

  function automatic bcf_pkg::seg_t rand_segment();
    bcf_pkg::seg_t s;
    s.p0_x = rand_coord();
    s.p0_y = rand_coord();
    s.p1_x = rand_coord();
    s.p1_y = rand_coord();
    s.p2_x = rand_coord();
    s.p2_y = rand_coord();
    s.p3_x = rand_coord();
    s.p3_y = rand_coord();
    return s;
  endfunction

  // Monitor: predict on accepted segments, check accepted points, track register writes.
  always @(posedge clk_i) begin
    bcf_pkg::pt_t exp_pt;
    if (rst_ni) begin
      if (seg_if.valid && seg_if.ready) begin
        flatten_segment(seg_if.data);
        seg_taken = 1'b1;
      end
      if (pt_if.valid && pt_if.ready) begin
        pt_taken = 1'b1;
        if (pending_points.size() == 0) begin
          $error("unexpected point word: x %0d y %0d index %0d", pt_if.data.pt_x,
                 pt_if.data.pt_y, pt_if.data.sample_index);
          err_count++;
        end else begin
          exp_pt = pending_points.pop_front();
          if (pt_if.data.pt_x !== exp_pt.pt_x) begin
            $error("pt_x: expected %0d, got %0d", exp_pt.pt_x, pt_if.data.pt_x);
            err_count++;
          end
          if (pt_if.data.pt_y !== exp_pt.pt_y) begin
            $error("pt_y: expected %0d, got %0d", exp_pt.pt_y, pt_if.data.pt_y);
            err_count++;
          end
          if (pt_if.data.sample_index !== exp_pt.sample_index) begin
            $error("sample_index: expected %0d, got %0d", exp_pt.sample_index,
                   pt_if.data.sample_index);
            err_count++;
          end
          if (pt_if.data.last !== exp_pt.last) begin
            $error("last: expected %0d, got %0d", exp_pt.last, pt_if.data.last);
            err_count++;
          end
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        if (cfg_if.index == bcf_pkg::REG_NUM_SEGMENTS) begin
          cfg_segments = cfg_if.data[bcf_pkg::NSEG_W-1:0];
        end else if (cfg_if.index == bcf_pkg::REG_T_STEP) begin
          cfg_step = cfg_if.data;
        end
      end
    end
  end

  // Segment driver: one word at a time from the queue, after a random gap when src_idle is set.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      seg_if.valid <= 1'b0;
      seg_if.data  <= '0;
    end else begin
      if (seg_taken) begin
        seg_taken  = 1'b0;
        seg_loaded = 1'b0;
      end
      if (!seg_loaded && segment_queue.size() != 0) begin
        seg_word   = segment_queue.pop_front();
        seg_gap    = src_idle ? $urandom_range(0, MAX_GAP) : 0;
        seg_loaded = 1'b1;
      end
      if (seg_loaded && seg_gap == 0) begin
        seg_if.valid <= 1'b1;
        seg_if.data  <= seg_word;
      end else begin
        if (seg_loaded) seg_gap--;
        seg_if.valid <= 1'b0;
      end
    end
  end

  // Point receiver: random stall per word when snk_idle is set, plus an optional long hold.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pt_if.ready <= 1'b0;
    end else begin
      if (snk_hold_req != 0) begin
        snk_hold_left = snk_hold_req;
        snk_hold_req  = 0;
      end
      if (pt_taken) begin
        pt_taken = 1'b0;
        snk_wait = snk_idle ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (snk_hold_left != 0) begin
        snk_hold_left--;
        pt_if.ready <= 1'b0;
      end else if (snk_wait != 0) begin
        snk_wait--;
        pt_if.ready <= 1'b0;
      end else begin
        pt_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_segment(input bcf_pkg::seg_t seg);
    segment_queue.insert(segment_queue.size(), seg);
  endtask

  task automatic write_reg(input logic [bcf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bcf_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Wait until every queued segment is taken and every point has come back.
  task automatic drain();
    while (segment_queue.size() != 0 || seg_loaded || pending_points.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int unsigned       p;
    int unsigned       k;
    int unsigned       sel;
    int unsigned       nseg;
    int unsigned       step;
    logic [bcf_pkg::CFG_DATA_W-1:0] wdata;

    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data  = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset registers: extremes of the coordinates.
    send_segment('0);
    send_segment({8{bcf_pkg::COORD_MAX}});
    send_segment({8{bcf_pkg::COORD_MIN}});
    send_segment({bcf_pkg::COORD_MAX, bcf_pkg::COORD_MIN, bcf_pkg::COORD_MIN,
                  bcf_pkg::COORD_MAX, bcf_pkg::COORD_MAX, bcf_pkg::COORD_MIN,
                  bcf_pkg::COORD_MIN, bcf_pkg::COORD_MAX});
    send_segment(rand_segment());
    send_segment(rand_segment());
    drain();

    // Zero segment count acts as one; largest step.
    write_reg(bcf_pkg::REG_NUM_SEGMENTS, '0);
    write_reg(bcf_pkg::REG_T_STEP, '1);
    send_segment(rand_segment());
    send_segment({8{bcf_pkg::COORD_MIN}});
    drain();

    // Count above the maximum, with t running past one.
    write_reg(bcf_pkg::REG_NUM_SEGMENTS, '1);
    write_reg(bcf_pkg::REG_T_STEP, bcf_pkg::CFG_DATA_W'(2000));
    send_segment(rand_segment());
    send_segment({bcf_pkg::COORD_MIN, bcf_pkg::COORD_MAX, bcf_pkg::COORD_MAX,
                  bcf_pkg::COORD_MIN, bcf_pkg::COORD_MIN, bcf_pkg::COORD_MAX,
                  bcf_pkg::COORD_MAX, bcf_pkg::COORD_MIN});
    drain();

    // Zero step, then writes to unused indexes that must change nothing.
    write_reg(bcf_pkg::REG_NUM_SEGMENTS, bcf_pkg::CFG_DATA_W'(3));
    write_reg(bcf_pkg::REG_T_STEP, '0);
    write_reg(FIRST_UNUSED_REG, '1);
    write_reg(bcf_pkg::CFG_IDX_W'($urandom_range(FIRST_UNUSED_REG,
                                                 (1 << bcf_pkg::CFG_IDX_W) - 1)), '1);
    send_segment(rand_segment());
    drain();

    write_reg(bcf_pkg::REG_NUM_SEGMENTS, bcf_pkg::CFG_DATA_W'(bcf_pkg::MAX_SEGMENTS));
    write_reg(bcf_pkg::REG_T_STEP, bcf_pkg::CFG_DATA_W'(1024));
    send_segment(rand_segment());
    drain();

    write_reg(bcf_pkg::REG_NUM_SEGMENTS, bcf_pkg::CFG_DATA_W'(1));
    write_reg(bcf_pkg::REG_T_STEP, bcf_pkg::CFG_DATA_W'(1));
    send_segment(rand_segment());
    send_segment(rand_segment());
    drain();

    write_reg(bcf_pkg::REG_NUM_SEGMENTS, bcf_pkg::CFG_DATA_W'(bcf_pkg::MAX_SEGMENTS + 1));
    write_reg(bcf_pkg::REG_T_STEP, '1);
    send_segment(rand_segment());
    drain();

    for (p = 0; p < RAND_PHASES; p++) begin
      sel = $urandom_range(0, 9);
      if (sel < 6) nseg = $urandom_range(1, 12);
      else if (sel == 6) nseg = 0;
      else if (sel == 7) nseg = bcf_pkg::MAX_SEGMENTS;
      else nseg = $urandom_range(13, NSEG_FIELD_MAX);
      sel  = $urandom_range(0, 3);
      step = 32'(T_UNIT / longint'((nseg == 0) ? 1 : nseg));
      if (sel == 1) step = $urandom_range(0, 65535);
      else if (sel == 2) step = 65535;
      else if (sel == 3) step = step + $urandom_range(0, 64) - 32;
      if (step > 65535) step = 65535;
      wdata = bcf_pkg::CFG_DATA_W'($urandom);
      wdata[bcf_pkg::NSEG_W-1:0] = nseg[bcf_pkg::NSEG_W-1:0];
      write_reg(bcf_pkg::REG_NUM_SEGMENTS, wdata);
      write_reg(bcf_pkg::REG_T_STEP, bcf_pkg::CFG_DATA_W'(step));
      if ($urandom_range(0, 3) == 0)
        write_reg(bcf_pkg::CFG_IDX_W'($urandom_range(FIRST_UNUSED_REG,
                                                     (1 << bcf_pkg::CFG_IDX_W) - 1)),
                  bcf_pkg::CFG_DATA_W'($urandom));

      src_idle = 1'($urandom_range(0, 1));
      snk_idle = 1'($urandom_range(0, 1));
      if (p == 2) begin
        // Back up the output so the input stalls while words keep coming.
        src_idle     = 1'b0;
        snk_hold_req = HOLD_CYCLES;
      end
      for (k = 0; k < PHASE_WORDS; k++) begin
        send_segment(rand_segment());
        // On odd phases, pause the sender mid-phase until all points are back.
        if (p % 2 == 1 && k == PHASE_WORDS / 2) drain();
      end
      drain();
    end

    if (err_count == 0 && pending_points.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("status: fail");
    $finish;
  end

endmodule

FILE: sim.f
hdl/bcf_pkg.sv
hdl/bcf_seg_if.sv
hdl/bcf_pt_if.sv
hdl/bcf_cfg_if.sv
hdl/bcf_cell.sv
hdl/bcf_seq.sv
hdl/cubic_bezier_flattener_unit.sv
bench/cubic_bezier_flattener_unit_tb.sv
